// ===== design/pcbs_pkg.sv =====
// Package: shared types, constants and sequencer states for per-class box suppression.
`timescale 1ns / 1ps
package pcbs_pkg;

	localparam int MAX_DETECTIONS = 64;
	localparam int MAX_CLASSES    = 16;
	localparam int COORD_BITS     = 16;
	localparam int DET_BITS       = $clog2(MAX_DETECTIONS);
	localparam int CLS_BITS       = $clog2(MAX_CLASSES);
	localparam int SCORE_ADDR_BITS = DET_BITS + CLS_BITS;
	localparam int EXT_BITS       = COORD_BITS + 4;
	localparam int PROD_BITS      = 52;

	localparam logic [4:0]  CLS_LIMIT_RESET = 5'd1;
	localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_RUN  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic REPLY_RUN  = 1'b0;
	localparam logic REPLY_READ = 1'b1;

	localparam logic CFG_CLS_LIMIT = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  det_index;
		logic [3:0]  cls_id;
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
		logic [15:0] objectness;
		logic [15:0] class_score;
		logic [6:0]  detection_count;
	} in_t;

	typedef struct packed {
		logic        reply_kind;
		logic [15:0] final_score;
		logic [10:0] suppressed_total;
	} out_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} box_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_READ, ST_READ_W,
		ST_CLS, ST_OBJ, ST_OBJ_W, ST_CMP, ST_CMP_W1, ST_CMP_W2, ST_INS,
		ST_PA, ST_PA_W1, ST_PA_W2, ST_PB, ST_PB_W1, ST_PB_W2,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_TEST, ST_RESULT
	} state_t;

endpackage

// ===== design/pcbs_overlap.sv =====
// Doubled overlap extent of two boxes along one axis.
`timescale 1ns / 1ps
module pcbs_overlap (
	input  logic [pcbs_pkg::COORD_BITS-1:0]      ca,
	input  logic [pcbs_pkg::COORD_BITS-1:0]      sa,
	input  logic [pcbs_pkg::COORD_BITS-1:0]      cb,
	input  logic [pcbs_pkg::COORD_BITS-1:0]      sb,
	output logic signed [pcbs_pkg::EXT_BITS-1:0] ext
);
	import pcbs_pkg::*;

	logic signed [EXT_BITS-1:0] la, ra, lb, rb, l, r;

	always_comb begin
		la = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
		ra = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
		lb = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
		rb = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
		l  = (la > lb) ? la : lb;
		r  = (ra < rb) ? ra : rb;
		ext = r - l;
	end

endmodule

// ===== design/per_class_box_suppression_core.sv =====
// Top level: stores, sequencer and shared multiplier for per-class box suppression.
//
//  channel | direction | handshake         | word
//  in      | input     | in_valid/ready    | in_t: load, run or read request
//  out     | output    | out_valid/ready   | out_t: run done or read data
//  cfg     | input     | cfg_valid/ready   | cfg_index, cfg_data register write
//
// A run goes class by class: it reads each counted detection, inserts those with nonzero objectness
// into the score order by sort shifts, then walks the ordered boxes and compares each box with a
// nonzero score against every later box; the single multiplier and the single read port of each
// store set the pace.
// Reset clears control only; stores hold garbage until loaded.
// in_ready is high only in idle; a finished word waits in the output register.
`timescale 1ns / 1ps
module per_class_box_suppression_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcbs_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pcbs_pkg::out_t   out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data
);
	import pcbs_pkg::*;

	box_t        box_mem   [MAX_DETECTIONS];
	logic [15:0] obj_mem   [MAX_DETECTIONS];
	logic [15:0] score_mem [MAX_DETECTIONS*MAX_CLASSES];
	logic [DET_BITS-1:0] order_mem [MAX_DETECTIONS];

	state_t state_q, state_d;
	in_t    in_q;
	logic [4:0]  cls_limit_q, classes_q, cls_q;
	logic [15:0] threshold_q;
	logic [6:0]  count_q, i_q, j_q, n_q;
	logic [15:0] s_q, sb_q, res_score_q;
	logic        res_kind_q;
	logic [DET_BITS-1:0] o_q, b_q;
	logic [10:0] total_q;
	box_t        box_a_q;
	logic [15:0] wb_q, hb_q;
	logic signed [EXT_BITS-1:0] ow_q, oh_q;
	logic [32:0] area_q;
	logic [33:0] inter_q;
	logic [PROD_BITS-1:0] lhs_q, rhs_q;
	logic        out_valid_q;
	out_t        out_q;

	box_t        box_rd_q;
	logic [15:0] obj_rd_q, score_rd_q;
	logic [DET_BITS-1:0] order_rd_q;

	logic [DET_BITS-1:0] box_raddr, obj_raddr, order_raddr, order_waddr, order_wdata;
	logic [SCORE_ADDR_BITS-1:0] score_raddr, score_waddr;
	logic [15:0] score_wdata;
	logic        load_we, score_we, order_we;
	logic [34:0] mul_a;
	logic [16:0] mul_b;
	logic [PROD_BITS-1:0] prod;
	logic signed [EXT_BITS-1:0] ow_d, oh_d;
	logic        out_load;

	pcbs_overlap u_ovl_x (
		.ca(box_a_q.x), .sa(box_a_q.w), .cb(box_rd_q.x), .sb(box_rd_q.w), .ext(ow_d)
	);
	pcbs_overlap u_ovl_y (
		.ca(box_a_q.y), .sa(box_a_q.h), .cb(box_rd_q.y), .sb(box_rd_q.h), .ext(oh_d)
	);

	assign prod      = PROD_BITS'({17'd0, mul_a} * {35'd0, mul_b});
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.kind)
						KIND_LOAD: state_d = ST_LOAD;
						KIND_RUN:  state_d = ST_CLS;
						KIND_READ: state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:   state_d = ST_IDLE;
			ST_READ:   state_d = ST_READ_W;
			ST_READ_W: state_d = ST_RESULT;
			ST_CLS:    state_d = (cls_q == classes_q) ? ST_RESULT : ST_OBJ;
			ST_OBJ:    state_d = (i_q == count_q) ? ST_PA : ST_OBJ_W;
			ST_OBJ_W:  state_d = (obj_rd_q == 16'd0) ? ST_OBJ : ST_CMP;
			ST_CMP:    state_d = (j_q == 7'd0) ? ST_INS : ST_CMP_W1;
			ST_CMP_W1: state_d = ST_CMP_W2;
			ST_CMP_W2: state_d = (score_rd_q < s_q) ? ST_CMP : ST_INS;
			ST_INS:    state_d = ST_OBJ;
			ST_PA:     state_d = (i_q == n_q) ? ST_CLS : ST_PA_W1;
			ST_PA_W1:  state_d = ST_PA_W2;
			ST_PA_W2:  state_d = (score_rd_q == 16'd0) ? ST_PA : ST_PB;
			ST_PB:     state_d = (j_q == n_q) ? ST_PA : ST_PB_W1;
			ST_PB_W1:  state_d = ST_PB_W2;
			ST_PB_W2:  state_d = ST_M1;
			ST_M1:     state_d = ST_M2;
			ST_M2:     state_d = ST_M3;
			ST_M3:     state_d = ST_M4;
			ST_M4:     state_d = ST_M5;
			ST_M5:     state_d = ST_TEST;
			ST_TEST:   state_d = ST_PB;
			ST_RESULT: state_d = out_load ? ST_IDLE : ST_RESULT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// store ports and multiplier operands
	always_comb begin
		box_raddr   = in_q.det_index;
		obj_raddr   = i_q[DET_BITS-1:0];
		order_raddr = i_q[DET_BITS-1:0];
		score_raddr = {in_q.det_index, in_q.cls_id};
		score_waddr = {in_q.det_index, in_q.cls_id};
		score_wdata = in_q.class_score;
		order_waddr = j_q[DET_BITS-1:0];
		order_wdata = o_q;
		load_we     = 1'b0;
		score_we    = 1'b0;
		order_we    = 1'b0;
		mul_a       = 35'd0;
		mul_b       = 17'd0;
		case (state_q)
			ST_LOAD: begin
				load_we  = 1'b1;
				score_we = 1'b1;
			end
			ST_OBJ: score_raddr = {i_q[DET_BITS-1:0], cls_q[CLS_BITS-1:0]};
			ST_CMP: order_raddr = DET_BITS'(j_q - 7'd1);
			ST_CMP_W1: score_raddr = {order_rd_q, cls_q[CLS_BITS-1:0]};
			ST_CMP_W2: order_we = (score_rd_q < s_q);
			ST_INS: begin
				order_we    = 1'b1;
				order_wdata = i_q[DET_BITS-1:0];
			end
			ST_PA_W1, ST_PB_W1: begin
				box_raddr   = order_rd_q;
				score_raddr = {order_rd_q, cls_q[CLS_BITS-1:0]};
			end
			ST_PB: order_raddr = j_q[DET_BITS-1:0];
			ST_M1: begin
				mul_a = {19'd0, box_a_q.w};
				mul_b = {1'b0, box_a_q.h};
			end
			ST_M2: begin
				mul_a = {19'd0, wb_q};
				mul_b = {1'b0, hb_q};
			end
			ST_M3: begin
				mul_a = {18'd0, ow_q[16:0]};
				mul_b = oh_q[16:0];
			end
			ST_M4: begin
				mul_a = {1'b0, inter_q};
				mul_b = {1'b1, 16'd0} + {1'b0, threshold_q};
			end
			ST_M5: begin
				mul_a = {2'b00, area_q};
				mul_b = {1'b0, threshold_q};
			end
			ST_TEST: begin
				score_we    = (lhs_q > rhs_q);
				score_waddr = {b_q, cls_q[CLS_BITS-1:0]};
				score_wdata = 16'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			box_mem[in_q.det_index] <= '{x: in_q.box_x, y: in_q.box_y, w: in_q.box_w,
				h: in_q.box_h};
			obj_mem[in_q.det_index] <= in_q.objectness;
		end
		if (score_we)
			score_mem[score_waddr] <= score_wdata;
		if (order_we)
			order_mem[order_waddr] <= order_wdata;
		box_rd_q   <= box_mem[box_raddr];
		obj_rd_q   <= obj_mem[obj_raddr];
		score_rd_q <= score_mem[score_raddr];
		order_rd_q <= order_mem[order_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cls_limit_q <= CLS_LIMIT_RESET;
			threshold_q <= THRESHOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_CLS_LIMIT: cls_limit_q <= cfg_data[4:0];
					CFG_THRESHOLD: threshold_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				in_q        <= in_data;
				cls_q       <= 5'd0;
				total_q     <= 11'd0;
				res_score_q <= 16'd0;
				res_kind_q  <= (in_data.kind == KIND_READ) ? REPLY_READ : REPLY_RUN;
				count_q     <= (in_data.detection_count > 7'(MAX_DETECTIONS)) ?
					7'(MAX_DETECTIONS) : in_data.detection_count;
				classes_q   <= (cls_limit_q > 5'(MAX_CLASSES)) ?
					5'(MAX_CLASSES) : cls_limit_q;
			end
			ST_READ_W: res_score_q <= score_rd_q;
			ST_CLS: begin
				i_q <= 7'd0;
				n_q <= 7'd0;
			end
			ST_OBJ: begin
				if (i_q == count_q)
					i_q <= 7'd0;
			end
			ST_OBJ_W: begin
				if (obj_rd_q == 16'd0)
					i_q <= i_q + 7'd1;
				s_q <= score_rd_q;
				j_q <= n_q;
			end
			ST_CMP_W1: o_q <= order_rd_q;
			ST_CMP_W2: begin
				if (score_rd_q < s_q)
					j_q <= j_q - 7'd1;
			end
			ST_INS: begin
				n_q <= n_q + 7'd1;
				i_q <= i_q + 7'd1;
			end
			ST_PA: begin
				if (i_q == n_q)
					cls_q <= cls_q + 5'd1;
			end
			ST_PA_W2: begin
				if (score_rd_q == 16'd0)
					i_q <= i_q + 7'd1;
				box_a_q <= box_rd_q;
				j_q     <= i_q + 7'd1;
			end
			ST_PB: begin
				if (j_q == n_q)
					i_q <= i_q + 7'd1;
			end
			ST_PB_W1: b_q <= order_rd_q;
			ST_PB_W2: begin
				ow_q <= ow_d;
				oh_q <= oh_d;
				wb_q <= box_rd_q.w;
				hb_q <= box_rd_q.h;
				sb_q <= score_rd_q;
			end
			ST_M1: area_q <= prod[32:0];
			ST_M2: area_q <= area_q + prod[32:0];
			ST_M3: inter_q <= (ow_q < 0 || oh_q < 0) ? 34'd0 : prod[33:0];
			ST_M4: lhs_q <= prod;
			ST_M5: rhs_q <= {prod[PROD_BITS-3:0], 2'b00};
			ST_TEST: begin
				// count only scores that actually drop to zero
				if (lhs_q > rhs_q && sb_q != 16'd0)
					total_q <= total_q + 11'd1;
				j_q <= j_q + 7'd1;
			end
			default: begin
			end
		endcase
		if (out_load)
			out_q <= '{reply_kind: res_kind_q, final_score: res_score_q,
				suppressed_total: total_q};
	end

endmodule

// ===== design/pcbs_checker.sv =====
// Port checker for per_class_box_suppression_core, bound to the top level.
`timescale 1ns / 1ps
module pcbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input pcbs_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input pcbs_pkg::out_t out_data
);
	import pcbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word dropped or changed while stalled");

	// an unused kind is dropped in idle, so only real requests make the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind != KIND_NONE |=> !in_ready)
		else $error("input taken again before previous word finished");

	a_read_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reply_kind == REPLY_READ |-> out_data.suppressed_total == 11'd0)
		else $error("read reply carries a suppression count");

	a_run_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reply_kind == REPLY_RUN |-> out_data.final_score == 16'd0)
		else $error("run reply carries a score");

endmodule

bind per_class_box_suppression_core pcbs_checker u_pcbs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
